// File: design/pru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PNG row unfilter.
// No dependencies; imported by png_row_unfilter_top, pru_unfilter_check and the testbench.
package pru_pkg;

  localparam int MAX_ROW_PIXELS = 8192;
  localparam int MAX_BPP        = 4;
  localparam int STORE_DEPTH    = MAX_ROW_PIXELS * MAX_BPP;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);
  localparam int CFG_DW         = 16;
  localparam int CFG_IW         = 2;

  localparam logic [CFG_IW-1:0] CFG_ROW_PIXELS      = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_PICTURE_ROWS    = 2'd2;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

endpackage

// File: design/png_row_unfilter_top.sv
`timescale 1ns / 1ps
// PNG scanline unfilter: inflated bytes in, reconstructed sample bytes out.
// Depends on pru_pkg and pru_ram.
//
// Takes one inflated byte per cycle while the output is not stalled; a data
// byte's result passes through the stage 1 register into the output register.
// The registered read of the 32768 x 8 row store runs alongside the stage 1
// register, so its data is ready while the byte is in stage 1. The first byte
// of each row is the filter type and gives no result; bytes past the
// configured picture height are taken and dropped. The row store needs no
// clearing pass: on the first row its contents are ignored and zero is used,
// and every later row reads only columns written by the row before. A write
// to any configuration register restarts the picture and must be done while
// no transaction is in flight.
module png_row_unfilter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pru_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [pru_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_stream_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_pixel_byte,
  output logic [15:0]                 out_row_index,
  output logic [14:0]                 out_byte_column,
  output logic                        out_row_last
);
  import pru_pkg::*;

  // configuration
  logic [13:0] row_pixels_r;
  logic [2:0]  bpp_r;
  logic [15:0] picture_rows_r;

  // accept-side control
  logic                expect_filter_r;
  logic [STORE_AW-1:0] col_r;
  logic [15:0]         row_count_r;
  filter_t             filter_r;

  // stage 1 (row store read in flight)
  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic [STORE_AW-1:0] s1_col_r;
  logic [15:0]         s1_row_r;
  filter_t             s1_filter_r;
  logic                s1_last_r;
  logic                s1_first_px_r;
  logic                s1_top_row_r;

  logic [7:0] left_hist_r [MAX_BPP];
  logic [7:0] al_hist_r   [MAX_BPP];

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_row_r;
  logic [14:0] out_col_r;
  logic        out_last_r;

  // effective geometry
  logic        bpp4;
  logic [13:0] eff_pixels;
  logic [15:0] row_len;
  logic [2:0]  eff_bpp;

  always_comb begin
    bpp4 = (bpp_r >= 3'd4);
    eff_bpp = bpp4 ? 3'd4 : 3'd3;
    if (row_pixels_r == 14'd0) begin
      eff_pixels = 14'd1;
    end else if (row_pixels_r > 14'(MAX_ROW_PIXELS)) begin
      eff_pixels = 14'(MAX_ROW_PIXELS);
    end else begin
      eff_pixels = row_pixels_r;
    end
    if (bpp4) begin
      row_len = {eff_pixels, 2'b00};
    end else begin
      row_len = {2'b00, eff_pixels} + {1'b0, eff_pixels, 1'b0};
    end
  end

  // handshake
  logic in_accept, active, data_take, col_last, s1_adv, out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign active    = (row_count_r < picture_rows_r);
  assign data_take = in_accept && active && !expect_filter_r;
  assign col_last  = ({1'b0, col_r} + 16'd1) >= row_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pixels_r    <= 14'd1;
      bpp_r           <= 3'd3;
      picture_rows_r  <= 16'd1;
      expect_filter_r <= 1'b1;
      col_r           <= '0;
      row_count_r     <= '0;
      filter_r        <= FILT_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_PIXELS:      row_pixels_r   <= cfg_data[13:0];
        CFG_BYTES_PER_PIXEL: bpp_r          <= cfg_data[2:0];
        CFG_PICTURE_ROWS:    picture_rows_r <= cfg_data;
        default: ;
      endcase
      // restart the picture on any write to a real register
      if (cfg_index == CFG_ROW_PIXELS || cfg_index == CFG_BYTES_PER_PIXEL ||
          cfg_index == CFG_PICTURE_ROWS) begin
        expect_filter_r <= 1'b1;
        col_r           <= '0;
        row_count_r     <= '0;
        filter_r        <= FILT_NONE;
      end
    end else if (in_accept && active) begin
      if (expect_filter_r) begin
        filter_r        <= (in_stream_byte <= 8'd4) ? filter_t'(in_stream_byte[2:0])
                                                    : FILT_NONE;
        expect_filter_r <= 1'b0;
        col_r           <= '0;
      end else if (col_last) begin
        expect_filter_r <= 1'b1;
        row_count_r     <= row_count_r + 16'd1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // stage 1 load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (data_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_take) begin
      s1_byte_r     <= in_stream_byte;
      s1_col_r      <= col_r;
      s1_row_r      <= row_count_r;
      s1_filter_r   <= filter_r;
      s1_last_r     <= col_last;
      s1_first_px_r <= ({1'b0, col_r} < {13'd0, eff_bpp});
      s1_top_row_r  <= (row_count_r == 16'd0);
    end
  end

  // row store
  logic [7:0] ram_rdata;
  logic [7:0] value;

  pru_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (value),
    .re    (data_take),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // predictor
  logic [7:0]        above, left, up_left, pred;
  logic [8:0]        avg_sum;
  logic signed [9:0] d_b, d_a, d_p;
  logic [9:0]        pa, pb, pc;

  always_comb begin
    above   = s1_top_row_r ? 8'd0 : ram_rdata;
    left    = s1_first_px_r ? 8'd0 : (bpp4 ? left_hist_r[3] : left_hist_r[2]);
    up_left = s1_first_px_r ? 8'd0 : (bpp4 ? al_hist_r[3] : al_hist_r[2]);
    avg_sum = {1'b0, left} + {1'b0, above};
    d_b = $signed({2'b00, above}) - $signed({2'b00, up_left});
    d_a = $signed({2'b00, left}) - $signed({2'b00, up_left});
    d_p = d_a + d_b;
    pa  = d_b[9] ? 10'(-d_b) : 10'(d_b);
    pb  = d_a[9] ? 10'(-d_a) : 10'(d_a);
    pc  = d_p[9] ? 10'(-d_p) : 10'(d_p);
    case (s1_filter_r)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = above;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = left;
        end else if (pb <= pc) begin
          pred = above;
        end else begin
          pred = up_left;
        end
      end
      default:    pred = 8'd0;
    endcase
    value = s1_byte_r + pred;
  end

  // histories advance only on data bytes, newest first
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_hist_r[0] <= value;
      al_hist_r[0]   <= above;
      for (int i = 1; i < MAX_BPP; i++) begin
        left_hist_r[i] <= left_hist_r[i-1];
        al_hist_r[i]   <= al_hist_r[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= value;
      out_row_r  <= s1_row_r;
      out_col_r  <= s1_col_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_byte  = out_byte_r;
  assign out_row_index   = out_row_r;
  assign out_byte_column = out_col_r;
  assign out_row_last    = out_last_r;

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("stage 1 advanced but output register is empty");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline slot");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (data_take && col_last && !cfg_we) |=> expect_filter_r)
    else $error("last byte of row did not rearm filter byte");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= picture_rows_r || $past(cfg_we))
    else $error("row counter ran past picture height");

endmodule

// File: design/pru_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the previous row for png_row_unfilter_top.
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: verif/pru_unfilter_check.sv
`timescale 1ns / 1ps
// Result checker for png_row_unfilter_top: follows configuration writes and accepted
// stream bytes, predicts every reconstructed byte and compares the output channel.
// Depends on pru_pkg.
module pru_unfilter_check
  import pru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_stream_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_pixel_byte,
  input  logic [15:0]       out_row_index,
  input  logic [14:0]       out_byte_column,
  input  logic              out_row_last,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [7:0]  pixel;
    logic [15:0] row;
    logic [14:0] col;
    logic        last;
  } sample_t;

  sample_t     expected_samples[$];
  logic [7:0]  prior_row [STORE_DEPTH];
  logic [7:0]  left_hist [MAX_BPP];
  logic [7:0]  diag_hist [MAX_BPP];
  filter_t     row_filter;
  int unsigned byte_pos;
  int unsigned rows_done;
  logic [13:0] width_reg;
  logic [2:0]  bpp_reg;
  logic [15:0] height_reg;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, b, c);
    int ia, ib, ic, p, pa, pb, pc;
    ia = a;
    ib = b;
    ic = c;
    p  = ia + ib - ic;
    pa = (p > ia) ? p - ia : ia - p;
    pb = (p > ib) ? p - ib : ib - p;
    pc = (p > ic) ? p - ic : ic - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  task automatic restart_picture();
    foreach (prior_row[i]) prior_row[i] = 8'd0;
    foreach (left_hist[i]) begin
      left_hist[i] = 8'd0;
      diag_hist[i] = 8'd0;
    end
    row_filter = FILT_NONE;
    byte_pos   = 0;
    rows_done  = 0;
  endtask

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic unfilter_byte(input logic [7:0] x);
    int unsigned bpp, pixels, col;
    logic [7:0]  left, up, diag, pred, value;
    sample_t     entry;
    bpp    = (bpp_reg < 3) ? 3 : ((bpp_reg > MAX_BPP) ? MAX_BPP : bpp_reg);
    pixels = (width_reg == 0) ? 1 :
             ((width_reg > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : width_reg);
    // drop everything past the picture height
    if (rows_done >= height_reg) return;
    if (byte_pos == 0) begin
      row_filter = (x <= 8'd4) ? filter_t'(x[2:0]) : FILT_NONE;
      byte_pos   = 1;
      return;
    end
    col = byte_pos - 1;
    if (col >= STORE_DEPTH) col = STORE_DEPTH - 1;
    up   = prior_row[col];
    left = (col >= bpp) ? left_hist[bpp-1] : 8'd0;
    diag = (col >= bpp) ? diag_hist[bpp-1] : 8'd0;
    case (row_filter)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = 8'((9'(left) + 9'(up)) >> 1);
      FILT_PAETH: pred = paeth_pick(left, up, diag);
      default:    pred = 8'd0;
    endcase
    value = x + pred;
    prior_row[col] = value;
    for (int i = MAX_BPP - 1; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      diag_hist[i] = diag_hist[i-1];
    end
    left_hist[0] = value;
    diag_hist[0] = up;
    entry = '{value, rows_done[15:0], col[14:0], (col + 1 >= pixels * bpp)};
    expected_samples.push_back(entry);
    if (entry.last) begin
      byte_pos  = 0;
      rows_done = (rows_done + 1) & 32'hFFFF;
    end else begin
      byte_pos = col + 2;
    end
  endtask

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      width_reg  = 14'd1;
      bpp_reg    = 3'd3;
      height_reg = 16'd1;
      restart_picture();
      expected_samples.delete();
    end else begin
      // results are older than any byte taken at this edge: compare first
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch($sformatf("unexpected transaction row %0d col %0d byte %02h",
                                  out_row_index, out_byte_column, out_pixel_byte));
        end else begin
          want = expected_samples.pop_front();
          if (out_pixel_byte !== want.pixel)
            flag_mismatch($sformatf("row %0d col %0d pixel_byte got %02h want %02h",
                                    want.row, want.col, out_pixel_byte, want.pixel));
          if (out_row_index !== want.row)
            flag_mismatch($sformatf("row %0d col %0d row_index got %0d",
                                    want.row, want.col, out_row_index));
          if (out_byte_column !== want.col)
            flag_mismatch($sformatf("row %0d col %0d byte_column got %0d",
                                    want.row, want.col, out_byte_column));
          if (out_row_last !== want.last)
            flag_mismatch($sformatf("row %0d col %0d row_last got %b want %b",
                                    want.row, want.col, out_row_last, want.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_PIXELS: begin
            width_reg = cfg_data[13:0];
            restart_picture();
          end
          CFG_BYTES_PER_PIXEL: begin
            bpp_reg = cfg_data[2:0];
            restart_picture();
          end
          CFG_PICTURE_ROWS: begin
            height_reg = cfg_data;
            restart_picture();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) unfilter_byte(in_stream_byte);
    end
    pending = expected_samples.size();
  end

endmodule

// File: verif/tb_png_row_unfilter_top.sv
`timescale 1ns / 1ps
// Testbench top for png_row_unfilter_top: configures pictures and streams filtered rows
// with random idling on both sides; pru_unfilter_check predicts and compares.
// Depends on pru_pkg, png_row_unfilter_top and pru_unfilter_check.
module tb_png_row_unfilter_top;
  import pru_pkg::*;

  localparam logic [CFG_IW-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int                RANDOM_SAMPLES  = 800;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_stream_byte;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_pixel_byte;
  logic [15:0]       out_row_index;
  logic [14:0]       out_byte_column;
  logic              out_row_last;
  int                fail_count;
  int                pending;

  bit                gaps_on;
  bit                stalls_on;
  logic [13:0]       cur_pixels;
  logic [2:0]        cur_bpp;
  logic [15:0]       cur_rows;
  int                samples_sent;

  filter_t    opening_types [3]  = '{FILT_SUB, FILT_PAETH, FILT_AVG};
  logic [7:0] opening_bytes [18] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'h7F,
                                     8'h10, 8'hF0, 8'h00, 8'hFF, 8'h55, 8'hAA,
                                     8'hFF, 8'hFF, 8'h01, 8'h02, 8'h80, 8'hFE};

  png_row_unfilter_top DUT (.*);
  pru_unfilter_check u_check (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver backpressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // leaves cfg_we high; the caller lowers it after its last write
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_ROW_PIXELS:      cur_pixels = data[13:0];
      CFG_BYTES_PER_PIXEL: cur_bpp    = data[2:0];
      CFG_PICTURE_ROWS:    cur_rows   = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  // hold the stream until every result is out, then let filter bytes settle
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic play_picture(input logic [2:0] which, input logic [15:0] w, b, h,
                              input int rows, input int cut, input int tail);
    int pixels, bpp, n;
    drain();
    if (which[0]) write_reg(CFG_ROW_PIXELS, w);
    if (which[1]) write_reg(CFG_BYTES_PER_PIXEL, b);
    if (which[2]) write_reg(CFG_PICTURE_ROWS, h);
    cfg_we <= 1'b0;
    pixels = (cur_pixels == 0) ? 1 :
             ((cur_pixels > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : cur_pixels);
    bpp    = (cur_bpp < 3) ? 3 : ((cur_bpp > MAX_BPP) ? MAX_BPP : cur_bpp);
    for (int r = 0; r < rows; r++) begin
      n = pixels * bpp;
      // truncate the last row so the next restart lands mid-row
      if (r == rows - 1 && cut >= 0 && cut < n) n = cut;
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 255))
                                            : 8'($urandom_range(0, 4)));
      repeat (n) begin
        send_byte(($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                              : 8'($urandom));
      end
    end
    repeat (tail) send_byte(8'($urandom));
  endtask

  initial begin
    logic [15:0] w, b, h;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ROW_PIXELS;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_stream_byte = 8'd0;
    cur_pixels     = 14'd1;
    cur_bpp        = 3'd3;
    cur_rows       = 16'd1;
    samples_sent   = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: one RGB pixel, one row, Up against the zero row
    send_byte(8'(FILT_UP));
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h01);

    // two-pixel rows: Sub, Paeth, Average with wraparound values
    drain();
    write_reg(CFG_ROW_PIXELS, 16'd2);
    write_reg(CFG_BYTES_PER_PIXEL, 16'd3);
    write_reg(CFG_PICTURE_ROWS, 16'd3);
    cfg_we <= 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (r == 1) begin
        // a write outside the register list must not restart the picture
        drain();
        write_reg(CFG_SPARE_INDEX, 16'hFFFF);
        cfg_we <= 1'b0;
      end
      send_byte(8'(opening_types[r]));
      for (int k = 0; k < 6; k++) send_byte(opening_bytes[r * 6 + k]);
    end
    send_byte(8'(FILT_UP));
    send_byte(8'hFF);

    samples_sent = 0;
    while (samples_sent < RANDOM_SAMPLES) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 9) == 0) ? 16'd0 :
          (($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 40))
                                       : 16'($urandom_range(1, 8)));
      w[15:14] = 2'($urandom_range(0, 3));
      b = 16'($urandom);
      if ($urandom_range(0, 5) != 0) b[2:0] = 3'($urandom_range(3, 4));
      h = ($urandom_range(0, 11) == 0) ? 16'd0 :
          (($urandom_range(0, 11) == 0) ? 16'hFFFF : 16'($urandom_range(1, 5)));
      play_picture(3'($urandom_range(1, 7)), w, b, h, $urandom_range(1, 5),
                   ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 40)) : -1,
                   ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 4)) : 0);
    end

    // widest RGBA row, cut short
    play_picture(3'b111, 16'd8192, 16'd4, 16'd2, 1, 24, 0);
    // width and pixel size beyond range, picture cut short
    play_picture(3'b111, 16'hFFFF, 16'h0000, 16'd1, 1, 30, 0);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    play_picture(3'b111, 16'd5, 16'd4, 16'd3, 4, -1, 2);
    play_picture(3'b100, 16'd0, 16'd0, 16'd2, 2, -1, 0);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pru_pkg.sv
design/pru_ram.sv
design/png_row_unfilter_top.sv
verif/pru_unfilter_check.sv
verif/tb_png_row_unfilter_top.sv
